@@ rtl/cll_pkg.sv @@
package cll_pkg;

  // node array size and derived widths
  localparam int unsigned Nodes      = 32;
  localparam int unsigned IdxW       = $clog2(Nodes);
  localparam int unsigned MaxResults = Nodes - 1;
  localparam int unsigned WordW      = 32;
  localparam int unsigned PosW       = 5;
  localparam int unsigned CountW     = 5;

  typedef enum logic [1:0] {
    CmdAppend = 2'd0,
    CmdInsert = 2'd1,
    CmdRemove = 2'd2,
    CmdShow   = 2'd3
  } cll_cmd_e;

  typedef struct packed {
    cll_cmd_e          cmd;
    logic [PosW-1:0]   position;
    logic [WordW-1:0]  data_word;
  } cll_in_t;

  typedef struct packed {
    logic              ok;
    logic [WordW-1:0]  item_word;
    logic [CountW-1:0] count;
    logic              last;
  } cll_out_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic walk_adv;
    logic walk_end;
    logic ins_a;
    logic ins_b;
    logic rem_a;
    logic rem_b;
    logic rem_c;
    logic show_adv;
    logic emit_show;
    logic emit_result;
  } cll_ctrl_t;

  // datapath to controller
  typedef struct packed {
    cll_cmd_e in_cmd;
    logic     pre_fail;
    logic     op_remove;
    logic     walk_done;
    logic     link_zero;
    logic     show_fin;
    logic     out_free;
  } cll_stat_t;

  // link value of a node right after reset: head empty, free chain 1..Nodes-1
  function automatic logic [IdxW-1:0] link_reset(input logic [IdxW-1:0] idx);
    logic [IdxW-1:0] res;
    if (idx == '0 || idx == IdxW'(Nodes - 1)) begin
      res = '0;
    end else begin
      res = idx + 1'b1;
    end
    return res;
  endfunction

endpackage

@@ rtl/cursor_linked_list.sv @@
// Singly linked list of up to Nodes-1 words kept in a node array, with a
// free chain for unused nodes. Each input item is one command (append,
// insert after a position, remove at a position, show) and gives one
// result item, or for show one result item per stored word with last set
// on the final one. A command runs on the link memory's single read port,
// one link per cycle: after the accepting cycle, append, insert and remove
// walk to the target node, then relink in states InsA and InsB (insert,
// append) or RemA, RemB and RemC (remove) and post the result; a command
// that fails its range or full check goes straight to posting its result.
// Show lists the stored words in order while results are taken, and gives
// one result item on an empty list. A new item is accepted as soon as the
// previous command is done, even while its result still waits in the
// output register. After reset the block is ready at once; unwritten link
// entries read as their reset chain.
module cursor_linked_list (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cll_pkg::cll_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cll_pkg::cll_out_t out_data_o
);
  import cll_pkg::*;

  cll_ctrl_t ctrl;
  cll_stat_t stat;

  // command sequencer
  cll_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // list memories, cursor and result register
  cll_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/cll_ram.sv @@
module cll_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/cll_datapath.sv @@
module cll_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cll_pkg::cll_in_t   in_data_i,
  input  cll_pkg::cll_ctrl_t ctrl_i,
  output cll_pkg::cll_stat_t stat_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cll_pkg::cll_out_t  out_data_o
);
  import cll_pkg::*;

  localparam int unsigned CmpW = (IdxW > PosW) ? IdxW : PosW;

  logic [IdxW-1:0]  cur_q, cur_d;
  logic [IdxW-1:0]  cnt_q, cnt_d;
  logic [IdxW-1:0]  plink_q, plink_d;
  logic [IdxW-1:0]  free_head_q, free_head_d;
  logic [IdxW-1:0]  count_q, count_d;
  logic             ok_q, ok_d;
  logic [WordW-1:0] word_q, word_d;
  cll_cmd_e         cmd_q, cmd_d;
  logic             out_valid_q, out_valid_d;
  cll_out_t         out_q, out_d;

  logic [Nodes-1:0] link_vld_q, link_vld_d;
  logic             rd_vld_q;
  logic [IdxW-1:0]  rd_addr_q;
  logic [IdxW-1:0]  rd_addr;
  logic [IdxW-1:0]  link_raw;
  logic [IdxW-1:0]  link_rd;
  logic [WordW-1:0] pay_rd;
  logic             link_we;
  logic [IdxW-1:0]  link_waddr;
  logic [IdxW-1:0]  link_wdata;

  logic [PosW-1:0]  pos_n;
  logic [IdxW-1:0]  steps_in;
  logic             fail_in;
  logic             out_free;
  logic             show_fin;

  // link read data, falling back to the reset chain for unwritten nodes
  assign link_rd  = rd_vld_q ? link_raw : link_reset(rd_addr_q);
  assign show_fin = (link_rd == '0) || (cnt_q == IdxW'(MaxResults - 1));
  assign out_free = !out_valid_q || out_ready_i;

  // decode of the incoming item: walk length and early failure
  always_comb begin
    pos_n    = (in_data_i.position == '0) ? PosW'(1) : in_data_i.position;
    steps_in = '0;
    fail_in  = 1'b0;
    unique case (in_data_i.cmd)
      CmdAppend: begin
        steps_in = count_q;
        fail_in  = (free_head_q == '0);
      end
      CmdInsert: begin
        steps_in = IdxW'(in_data_i.position);
        fail_in  = (free_head_q == '0) ||
                   (CmpW'(in_data_i.position) > CmpW'(count_q));
      end
      CmdRemove: begin
        steps_in = IdxW'(pos_n - 1'b1);
        fail_in  = (CmpW'(pos_n) > CmpW'(count_q));
      end
      CmdShow: begin
        steps_in = '0;
        fail_in  = 1'b0;
      end
      default: begin
        steps_in = '0;
        fail_in  = 1'b0;
      end
    endcase
  end

  // cursor, counters and list registers
  always_comb begin
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    plink_d     = plink_q;
    free_head_d = free_head_q;
    count_d     = count_q;
    ok_d        = ok_q;
    word_d      = word_q;
    cmd_d       = cmd_q;
    if (ctrl_i.start) begin
      cur_d  = '0;
      cnt_d  = steps_in;
      ok_d   = 1'b0;
      word_d = in_data_i.data_word;
      cmd_d  = in_data_i.cmd;
    end
    if (ctrl_i.walk_adv) begin
      cur_d = link_rd;
      cnt_d = cnt_q - 1'b1;
    end
    if (ctrl_i.walk_end) begin
      plink_d = link_rd;
    end
    if (ctrl_i.show_adv) begin
      cur_d = link_rd;
    end
    if (ctrl_i.emit_show) begin
      cnt_d = cnt_q + 1'b1;
    end
    if (ctrl_i.ins_b) begin
      free_head_d = link_rd;
      count_d     = count_q + 1'b1;
      ok_d        = 1'b1;
    end
    if (ctrl_i.rem_c) begin
      free_head_d = plink_q;
      count_d     = count_q - 1'b1;
      ok_d        = 1'b1;
    end
  end

  // link memory ports
  always_comb begin
    rd_addr    = cur_d;
    link_we    = 1'b0;
    link_waddr = cur_q;
    link_wdata = free_head_q;
    unique if (ctrl_i.ins_a) begin
      rd_addr    = free_head_q;
      link_we    = 1'b1;
      link_waddr = cur_q;
      link_wdata = free_head_q;
    end else if (ctrl_i.ins_b) begin
      link_we    = 1'b1;
      link_waddr = free_head_q;
      link_wdata = plink_q;
    end else if (ctrl_i.rem_a) begin
      rd_addr = plink_q;
    end else if (ctrl_i.rem_b) begin
      link_we    = 1'b1;
      link_waddr = cur_q;
      link_wdata = link_rd;
    end else if (ctrl_i.rem_c) begin
      link_we    = 1'b1;
      link_waddr = plink_q;
      link_wdata = free_head_q;
    end else begin
      rd_addr = cur_d;
    end
  end

  // written marks for the link memory
  always_comb begin
    link_vld_d = link_vld_q;
    if (link_we) begin
      link_vld_d[link_waddr] = 1'b1;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (ctrl_i.emit_show) begin
      out_valid_d     = 1'b1;
      out_d.ok        = 1'b1;
      out_d.item_word = pay_rd;
      out_d.count     = CountW'(count_q);
      out_d.last      = show_fin;
    end else if (ctrl_i.emit_result) begin
      out_valid_d     = 1'b1;
      out_d.ok        = ok_q;
      out_d.item_word = '0;
      out_d.count     = CountW'(count_q);
      out_d.last      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= IdxW'(1);
      count_q     <= '0;
      link_vld_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      free_head_q <= free_head_d;
      count_q     <= count_d;
      link_vld_q  <= link_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    cnt_q     <= cnt_d;
    plink_q   <= plink_d;
    ok_q      <= ok_d;
    word_q    <= word_d;
    cmd_q     <= cmd_d;
    out_q     <= out_d;
    rd_vld_q  <= link_vld_q[rd_addr];
    rd_addr_q <= rd_addr;
  end

  cll_ram #(
    .Width (IdxW),
    .Depth (Nodes)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (rd_addr),
    .rdata_o (link_raw)
  );

  cll_ram #(
    .Width (WordW),
    .Depth (Nodes)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.ins_a),
    .waddr_i (free_head_q),
    .wdata_i (word_q),
    .raddr_i (rd_addr),
    .rdata_o (pay_rd)
  );

  // status
  assign stat_o.in_cmd    = in_data_i.cmd;
  assign stat_o.pre_fail  = fail_in;
  assign stat_o.op_remove = (cmd_q == CmdRemove);
  assign stat_o.walk_done = (cnt_q == '0);
  assign stat_o.link_zero = (link_rd == '0);
  assign stat_o.show_fin  = show_fin;
  assign stat_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // the free chain runs dry exactly when the list is full
  a_full_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_head_q == '0) == (count_q == IdxW'(Nodes - 1)))
    else $error("free chain and item count disagree");

  // a walk inside the list never meets the end of the chain
  a_walk_link : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.walk_adv |-> (link_rd != '0))
    else $error("walk ran off the end of the list");

  // show never lists the head node
  a_show_node : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.emit_show |-> (cur_q != '0))
    else $error("show emitted the head node");

  // a result is only loaded into a free output register
  a_out_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.emit_show || ctrl_i.emit_result) |-> out_free)
    else $error("result overwrote a pending item");

endmodule

@@ rtl/cll_ctrl.sv @@
module cll_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cll_pkg::cll_stat_t stat_i,
  output cll_pkg::cll_ctrl_t ctrl_o
);
  import cll_pkg::*;

  typedef enum logic [9:0] {
    StIdle     = 10'b00_0000_0001,
    StWalk     = 10'b00_0000_0010,
    StInsA     = 10'b00_0000_0100,
    StInsB     = 10'b00_0000_1000,
    StRemA     = 10'b00_0001_0000,
    StRemB     = 10'b00_0010_0000,
    StRemC     = 10'b00_0100_0000,
    StShowHead = 10'b00_1000_0000,
    StShow     = 10'b01_0000_0000,
    StResult   = 10'b10_0000_0000
  } cll_state_e;

  cll_state_e state_q, state_d;

  // sequencing of one command
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          ctrl_o.start = 1'b1;
          if (stat_i.in_cmd == CmdShow) begin
            state_d = StShowHead;
          end else if (stat_i.pre_fail) begin
            state_d = StResult;
          end else begin
            state_d = StWalk;
          end
        end
      end
      StWalk: begin
        if (stat_i.walk_done) begin
          ctrl_o.walk_end = 1'b1;
          state_d = stat_i.op_remove ? StRemA : StInsA;
        end else begin
          ctrl_o.walk_adv = 1'b1;
        end
      end
      StInsA: begin
        ctrl_o.ins_a = 1'b1;
        state_d      = StInsB;
      end
      StInsB: begin
        ctrl_o.ins_b = 1'b1;
        state_d      = StResult;
      end
      StRemA: begin
        ctrl_o.rem_a = 1'b1;
        state_d      = StRemB;
      end
      StRemB: begin
        ctrl_o.rem_b = 1'b1;
        state_d      = StRemC;
      end
      StRemC: begin
        ctrl_o.rem_c = 1'b1;
        state_d      = StResult;
      end
      StShowHead: begin
        if (stat_i.link_zero) begin
          state_d = StResult;
        end else begin
          ctrl_o.show_adv = 1'b1;
          state_d = StShow;
        end
      end
      StShow: begin
        if (stat_i.out_free) begin
          ctrl_o.emit_show = 1'b1;
          if (stat_i.show_fin) begin
            state_d = StIdle;
          end else begin
            ctrl_o.show_adv = 1'b1;
          end
        end
      end
      StResult: begin
        if (stat_i.out_free) begin
          ctrl_o.emit_result = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == StIdle);

endmodule

@@ bench/cursor_linked_list_test.sv @@
module cursor_linked_list_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cll_pkg::*;

  // run limit in cycles
  localparam int unsigned LimitCycles = 5_000_000;
  localparam int unsigned RandomItems = 480;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned TailCycles  = 2 * Nodes + 40;

  // list predictor and queue of expected result items
  class list_scoreboard;
    logic [IdxW-1:0]  link_mem [Nodes];
    logic [WordW-1:0] word_mem [Nodes];
    logic [IdxW-1:0]  free_ptr;
    int unsigned      num_items;
    cll_out_t         expected_q [$];
    int unsigned      errors;

    function new();
      for (int i = 0; i < Nodes; i++) begin
        link_mem[i] = (i == 0 || i == Nodes - 1) ? '0 : IdxW'(i + 1);
        word_mem[i] = '0;
      end
      free_ptr  = IdxW'(1);
      num_items = 0;
      errors    = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // node reached after stepping from the head, stops at the tail
    function logic [IdxW-1:0] node_at(int unsigned steps);
      logic [IdxW-1:0] node;
      node = '0;
      for (int unsigned i = 0; i < steps && i < Nodes; i++) begin
        if (link_mem[node] == '0) break;
        node = link_mem[node];
      end
      return node;
    endfunction

    // take a node off the free chain and link it after prev
    function bit place_after(logic [IdxW-1:0] prev, logic [WordW-1:0] word);
      logic [IdxW-1:0] node;
      node = free_ptr;
      if (node == '0) return 1'b0;
      free_ptr       = link_mem[node];
      word_mem[node] = word;
      link_mem[node] = link_mem[prev];
      link_mem[prev] = node;
      num_items++;
      return 1'b1;
    endfunction

    function void push_result(bit ok, logic [WordW-1:0] word, bit fin);
      cll_out_t r;
      r.ok        = ok;
      r.item_word = word;
      r.count     = CountW'(num_items);
      r.last      = fin;
      expected_q.push_back(r);
    endfunction

    // apply one accepted command and queue the result items it causes
    function void note_command(cll_in_t c);
      bit              ok;
      int unsigned     n;
      int unsigned     k;
      logic [IdxW-1:0] prev;
      logic [IdxW-1:0] victim;
      logic [IdxW-1:0] node;
      ok = 1'b0;
      case (c.cmd)
        CmdAppend: begin
          ok = place_after(node_at(num_items), c.data_word);
        end
        CmdInsert: begin
          if (c.position <= num_items) ok = place_after(node_at(c.position), c.data_word);
        end
        CmdRemove: begin
          n = (c.position == '0) ? 1 : c.position;
          if (n <= num_items) begin
            prev   = node_at(n - 1);
            victim = link_mem[prev];
            if (victim != '0) begin
              link_mem[prev]   = link_mem[victim];
              link_mem[victim] = free_ptr;
              free_ptr         = victim;
              num_items--;
              ok = 1'b1;
            end
          end
        end
        default: begin
          // show: one item per stored word, capped at MaxResults
          k    = 0;
          node = link_mem[0];
          while (node != '0 && k < MaxResults) begin
            push_result(1'b1, word_mem[node],
                        link_mem[node] == '0 || k == MaxResults - 1);
            node = link_mem[node];
            k++;
          end
          if (k == 0) push_result(1'b0, '0, 1'b1);
          return;
        end
      endcase
      push_result(ok, '0, 1'b1);
    endfunction

    // compare one accepted result item with the oldest expectation
    function void check_result(cll_out_t got);
      cll_out_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unexpected result ok=%0b word=%h count=%0d last=%0b",
                   $time, got.ok, got.item_word, got.count, got.last);
        return;
      end
      exp = expected_q.pop_front();
      if (got.ok !== exp.ok || got.item_word !== exp.item_word ||
          got.count !== exp.count || got.last !== exp.last) begin
        errors++;
        if (errors <= 40)
          $display("%0t: mismatch expected ok=%0b word=%h count=%0d last=%0b, got ok=%0b word=%h count=%0d last=%0b",
                   $time, exp.ok, exp.item_word, exp.count, exp.last,
                   got.ok, got.item_word, got.count, got.last);
      end
    endfunction
  endclass

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  cll_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  cll_out_t out_data;

  list_scoreboard sb = new();

  int unsigned results_seen = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;
  int unsigned stall_left   = 0;
  int unsigned rx_cycles    = 0;

  cursor_linked_list dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #5 clk_i = ~clk_i;

  // idle length: mostly short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic cll_in_t make_item(cll_cmd_e cmd, int unsigned pos,
                                        logic [WordW-1:0] word);
    cll_in_t c;
    c.cmd       = cmd;
    c.position  = PosW'(pos);
    c.data_word = word;
    return c;
  endfunction

  // random command, biased by phase: grow, mixed or shrink
  function automatic cll_in_t random_item(int unsigned phase);
    int unsigned roll;
    int unsigned lim;
    cll_cmd_e    cmd;
    logic [WordW-1:0] word;
    roll = $urandom_range(99);
    case (phase)
      0: cmd = roll < 45 ? CmdAppend : roll < 85 ? CmdInsert : roll < 93 ? CmdRemove : CmdShow;
      1: cmd = roll < 25 ? CmdAppend : roll < 50 ? CmdInsert : roll < 80 ? CmdRemove : CmdShow;
      default:
         cmd = roll < 5 ? CmdAppend : roll < 10 ? CmdInsert : roll < 92 ? CmdRemove : CmdShow;
    endcase
    lim = (sb.num_items + 1 > 31) ? 31 : sb.num_items + 1;
    roll = $urandom_range(19);
    word = (roll == 0) ? '0 : (roll == 1) ? '1 : $urandom();
    if ($urandom_range(9) == 0) return make_item(cmd, $urandom_range(31), word);
    return make_item(cmd, $urandom_range(lim), word);
  endfunction

  // offer one item and hold it until accepted
  task automatic send_item(input cll_in_t c);
    in_valid <= 1'b1;
    in_data  <= c;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sb.note_command(c);
  endtask

  task automatic idle_sender(input int unsigned n);
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // result side: check accepted items, drive ready with stalls
  always @(posedge clk_i) begin
    rx_cycles++;
    if (rst_ni && out_valid && out_ready) begin
      sb.check_result(out_data);
      results_seen++;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= 120) begin
      // long hold-off so the block fills up and stalls its input
      hold_done = 1'b1;
      hold_left = HoldCycles;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ((rx_cycles / 1000) % 4 != 3 && $urandom_range(7) == 0) begin
      stall_left = idle_len();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // run limit
  initial begin
    int unsigned n;
    n = 0;
    while (n < LimitCycles) begin
      @(posedge clk_i);
      n++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // stimulus
  initial begin
    cll_in_t     directed_q [$];
    int unsigned phase;
    int unsigned gap;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list, ends, tail insert, out-of-range positions
    directed_q.push_back(make_item(CmdShow,   0,  32'h0));
    directed_q.push_back(make_item(CmdRemove, 0,  32'h0));
    directed_q.push_back(make_item(CmdInsert, 1,  32'h1111_1111));
    directed_q.push_back(make_item(CmdInsert, 0,  32'h0000_0000));
    directed_q.push_back(make_item(CmdAppend, 31, 32'hFFFF_FFFF));
    directed_q.push_back(make_item(CmdInsert, 2,  32'hA5A5_A5A5));
    directed_q.push_back(make_item(CmdInsert, 4,  32'h2222_2222));
    directed_q.push_back(make_item(CmdInsert, 1,  32'h5A5A_5A5A));
    directed_q.push_back(make_item(CmdInsert, 31, 32'h3333_3333));
    directed_q.push_back(make_item(CmdShow,   0,  32'hFFFF_FFFF));
    directed_q.push_back(make_item(CmdRemove, 0,  32'h0));
    directed_q.push_back(make_item(CmdRemove, 3,  32'h0));
    directed_q.push_back(make_item(CmdRemove, 31, 32'h0));
    directed_q.push_back(make_item(CmdRemove, 3,  32'h0));
    directed_q.push_back(make_item(CmdShow,   0,  32'h0));
    directed_q.push_back(make_item(CmdRemove, 2,  32'h0));
    directed_q.push_back(make_item(CmdRemove, 1,  32'h0));
    directed_q.push_back(make_item(CmdRemove, 1,  32'h0));
    directed_q.push_back(make_item(CmdAppend, 0,  32'h1234_5678));
    directed_q.push_back(make_item(CmdShow,   31, 32'h0));
    foreach (directed_q[i]) begin
      send_item(directed_q[i]);
      idle_sender(idle_len());
    end

    // random: phases long enough to fill the list and drain it again
    for (int unsigned i = 0; i < RandomItems; i++) begin
      if (i == RandomItems / 2) begin
        // pause until every expected item has come back
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
      end
      case ((i / 40) % 4)
        0, 3:    phase = 0;
        1:       phase = 1;
        default: phase = 2;
      endcase
      send_item(random_item(phase));
      gap = idle_len();
      if (hold_left != 0 || (i / 64) % 5 == 4) gap = 0;
      idle_sender(gap);
    end
    in_valid <= 1'b0;

    // drain, then allow the block's latency for stray items
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ cursor_linked_list.f @@
rtl/cll_pkg.sv
rtl/cll_ram.sv
rtl/cll_datapath.sv
rtl/cll_ctrl.sv
rtl/cursor_linked_list.sv
bench/cursor_linked_list_test.sv
